FILE: rtl/dmsfp_pkg.sv
// types and constants shared by the dual-mode serial frame parser
// no dependencies
`default_nettype none

package dmsfp_pkg;

  // sync bytes
  localparam logic [7:0] SYNC_A = 8'h55;
  localparam logic [7:0] SYNC_B = 8'hAA;

  // crc-16-ccitt
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // register reset values
  localparam logic [9:0] MAX_LEN_SUM_RST = 10'd500;
  localparam logic [9:0] MAX_LEN_CRC_RST = 10'd16;

  typedef enum logic [2:0] {
    EV_HUNT    = 3'd0,
    EV_HEADER  = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_GOOD    = 3'd3,
    EV_ABORT   = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_BAD_SYNC = 2'd1,
    CAUSE_TOO_LONG = 2'd2,
    CAUSE_CHECK    = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    CFG_CRC_MODE    = 2'd0,
    CFG_MAX_LEN_SUM = 2'd1,
    CFG_MAX_LEN_CRC = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic       crc_mode;
    logic [9:0] max_len_sum;
    logic [9:0] max_len_crc;
    logic       mode_clr;
  } cfg_t;

  typedef struct packed {
    event_e      event_res;
    cause_e      abort_cause;
    logic [7:0]  data_byte;
    logic [8:0]  payload_index;
    logic [15:0] frame_command;
    logic [9:0]  frame_length;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/dmsfp_cfg.sv
// configuration registers of the frame parser
// depends on dmsfp_pkg
`default_nettype none

module dmsfp_cfg
  import dmsfp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  output cfg_t            cfg_o
);

  logic       crc_mode_q, crc_mode_d;
  logic [9:0] max_len_sum_q, max_len_sum_d;
  logic [9:0] max_len_crc_q, max_len_crc_d;
  logic       mode_clr;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    crc_mode_d    = crc_mode_q;
    max_len_sum_d = max_len_sum_q;
    max_len_crc_d = max_len_crc_q;
    mode_clr      = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CRC_MODE: begin
          crc_mode_d = cfg_data_i[0];
          mode_clr   = cfg_data_i[0] != crc_mode_q;
        end
        CFG_MAX_LEN_SUM: max_len_sum_d = cfg_data_i;
        CFG_MAX_LEN_CRC: max_len_crc_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_mode_q    <= 1'b0;
      max_len_sum_q <= MAX_LEN_SUM_RST;
      max_len_crc_q <= MAX_LEN_CRC_RST;
    end else begin
      crc_mode_q    <= crc_mode_d;
      max_len_sum_q <= max_len_sum_d;
      max_len_crc_q <= max_len_crc_d;
    end
  end

  assign cfg_o.crc_mode    = crc_mode_q;
  assign cfg_o.max_len_sum = max_len_sum_q;
  assign cfg_o.max_len_crc = max_len_crc_q;
  assign cfg_o.mode_clr    = mode_clr;

endmodule

`default_nettype wire

FILE: rtl/dmsfp_core.sv
// frame state and per-word parse logic of the frame parser
// depends on dmsfp_pkg
`default_nettype none

module dmsfp_core
  import dmsfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire cfg_t       cfg_i,
  output res_t            res_o
);

  // limit registers are 10 bits wide, so the usable limit never exceeds 1023
  localparam int unsigned LimMax = (MAX_PAYLOAD > 1023) ? 1023 : MAX_PAYLOAD;
  localparam int unsigned PosW   = $clog2(LimMax + 7);
  localparam logic [9:0]  LimCap = 10'(LimMax);

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     cmd_q, cmd_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_lo_q, crc_lo_d;

  logic [7:0]      b;
  logic [9:0]      lim_reg;
  logic [9:0]      limit;
  logic [15:0]     len_new;
  logic [9:0]      len_sat;
  logic [PosW-1:0] len_pos;
  logic [7:0]      sum_nxt;
  logic [15:0]     crc_nxt;
  logic            clr;

  assign b       = rx_byte_i;
  assign lim_reg = cfg_i.crc_mode ? cfg_i.max_len_crc : cfg_i.max_len_sum;
  assign limit   = (lim_reg > LimCap) ? LimCap : lim_reg;
  assign len_new = cfg_i.crc_mode ? {b, len_q[7:0]} : {len_q[15:8], b};
  assign len_sat = (|len_new[15:10]) ? 10'h3FF : len_new[9:0];
  assign len_pos = len_q[PosW-1:0];
  assign sum_nxt = sum_q + b;
  assign crc_nxt = crc_byte(crc_q, b);

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    cmd_d    = cmd_q;
    sum_d    = sum_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    clr      = 1'b0;

    res_o.event_res     = EV_HUNT;
    res_o.abort_cause   = CAUSE_NONE;
    res_o.data_byte     = 8'h00;
    res_o.payload_index = 9'd0;
    res_o.frame_command = 16'h0000;
    res_o.frame_length  = 10'd0;

    if (!cfg_i.crc_mode) begin
      // sum mode: 55 AA len_hi len_lo cmd_hi cmd_lo payload sum
      if (pos_q == PosW'(0)) begin
        if (b == SYNC_A) begin
          res_o.event_res = EV_HEADER;
          sum_d = b;
          pos_d = PosW'(1);
        end else begin
          clr = 1'b1;
        end
      end else if (pos_q == PosW'(1)) begin
        if (b == SYNC_B) begin
          res_o.event_res = EV_HEADER;
          sum_d = sum_nxt;
          pos_d = PosW'(2);
        end else begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_BAD_SYNC;
          clr = 1'b1;
        end
      end else if (pos_q == PosW'(2)) begin
        len_d = {b, 8'h00};
        res_o.event_res = EV_HEADER;
        sum_d = sum_nxt;
        pos_d = PosW'(3);
      end else if (pos_q == PosW'(3)) begin
        len_d = len_new;
        res_o.frame_length = len_sat;
        if (len_new > {6'd0, limit}) begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_TOO_LONG;
          clr = 1'b1;
        end else begin
          res_o.event_res = EV_HEADER;
          sum_d = sum_nxt;
          pos_d = PosW'(4);
        end
      end else if (pos_q == PosW'(4)) begin
        cmd_d = {b, 8'h00};
        res_o.frame_length = len_q[9:0];
        res_o.event_res = EV_HEADER;
        sum_d = sum_nxt;
        pos_d = PosW'(5);
      end else if (pos_q == PosW'(5)) begin
        cmd_d = {cmd_q[15:8], b};
        res_o.frame_length  = len_q[9:0];
        res_o.frame_command = {cmd_q[15:8], b};
        res_o.event_res = EV_HEADER;
        sum_d = sum_nxt;
        pos_d = PosW'(6);
      end else if (pos_q < len_pos + PosW'(6)) begin
        res_o.frame_length  = len_q[9:0];
        res_o.frame_command = cmd_q;
        res_o.event_res     = EV_PAYLOAD;
        res_o.data_byte     = b;
        res_o.payload_index = 9'(pos_q - PosW'(6));
        sum_d = sum_nxt;
        pos_d = pos_q + PosW'(1);
      end else begin
        res_o.frame_length  = len_q[9:0];
        res_o.frame_command = cmd_q;
        if (b == sum_q) begin
          res_o.event_res = EV_GOOD;
        end else begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_CHECK;
        end
        clr = 1'b1;
      end
    end else begin
      // crc mode: AA 55 len_lo len_hi payload crc_lo crc_hi
      if (pos_q == PosW'(0)) begin
        if (b == SYNC_B) begin
          res_o.event_res = EV_HEADER;
          crc_d = crc_byte(16'h0000, b);
          pos_d = PosW'(1);
        end else begin
          clr = 1'b1;
        end
      end else if (pos_q == PosW'(1)) begin
        if (b == SYNC_A) begin
          res_o.event_res = EV_HEADER;
          crc_d = crc_nxt;
          pos_d = PosW'(2);
        end else begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_BAD_SYNC;
          clr = 1'b1;
        end
      end else if (pos_q == PosW'(2)) begin
        len_d = {8'h00, b};
        res_o.event_res = EV_HEADER;
        crc_d = crc_nxt;
        pos_d = PosW'(3);
      end else if (pos_q == PosW'(3)) begin
        len_d = len_new;
        res_o.frame_length = len_sat;
        if (len_new > {6'd0, limit}) begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_TOO_LONG;
          clr = 1'b1;
        end else begin
          res_o.event_res = EV_HEADER;
          crc_d = crc_nxt;
          pos_d = PosW'(4);
        end
      end else if (pos_q < len_pos + PosW'(4)) begin
        res_o.frame_length  = len_q[9:0];
        res_o.event_res     = EV_PAYLOAD;
        res_o.data_byte     = b;
        res_o.payload_index = 9'(pos_q - PosW'(4));
        crc_d = crc_nxt;
        pos_d = pos_q + PosW'(1);
      end else if (pos_q == len_pos + PosW'(4)) begin
        res_o.frame_length = len_q[9:0];
        crc_lo_d = b;
        res_o.event_res = EV_HEADER;
        pos_d = pos_q + PosW'(1);
      end else begin
        res_o.frame_length = len_q[9:0];
        if ({b, crc_lo_q} == crc_q) begin
          res_o.event_res = EV_GOOD;
        end else begin
          res_o.event_res   = EV_ABORT;
          res_o.abort_cause = CAUSE_CHECK;
        end
        clr = 1'b1;
      end
    end

    if (clr) begin
      pos_d = '0;
      sum_d = 8'h00;
      crc_d = 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= 16'h0000;
      cmd_q    <= 16'h0000;
      sum_q    <= 8'h00;
      crc_q    <= 16'h0000;
      crc_lo_q <= 8'h00;
    end else if (cfg_i.mode_clr) begin
      pos_q <= '0;
      sum_q <= 8'h00;
      crc_q <= 16'h0000;
    end else if (step_i) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      cmd_q    <= cmd_d;
      sum_q    <= sum_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dual_mode_serial_frame_parser.sv
// top level of the dual-mode serial frame parser: input and result registers
// depends on dmsfp_pkg, dmsfp_cfg, dmsfp_core
`default_nettype none

// usage
//   input channel: one received serial byte per word (in_valid_i / in_ready_o)
//   result channel: one event word per input word (out_valid_o / out_ready_i),
//     carrying event code, abort cause, payload byte and index, command, length
//   config channel: cfg_index_i selects crc_mode (0), max_len_sum (1) or
//     max_len_crc (2); other indexes are dropped; always ready
// path: a word taken sits in the input register; the parse logic runs
//   between the input and result registers, and its event is shown on the
//   result port once the result register takes it, which a stall can delay
// throughput: one word per cycle unless the result port stalls; the bound is
//   the parse step (position decode plus eight-step crc update of one byte)
// stall: while the result register is full and not taken, the input register
//   holds its word and in_ready_o stays high only while that register is free
// reset: parser hunts for the first sync byte with cleared sums, crc_mode 0,
//   max_len_sum 500, max_len_crc 16; both data registers come up empty
// a crc_mode write with a new value drops any frame in progress

module dual_mode_serial_frame_parser
  import dmsfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // received bytes
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  // events
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [1:0]       abort_cause_o,
  output logic [7:0]       data_byte_o,
  output logic [8:0]       payload_index_o,
  output logic [15:0]      frame_command_o,
  output logic [9:0]       frame_length_o,
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [9:0]  cfg_data_i
);

  cfg_t       cfg;
  res_t       res;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  logic       step;
  logic       in_take;

  dmsfp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dmsfp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // a word moves from the input register to the result register when the
  // result register is empty or being drained in this cycle
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (step) begin
      in_valid_d = 1'b0;
    end
    if (in_take) begin
      in_valid_d = 1'b1;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // data registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = out_res_q.event_res;
  assign abort_cause_o   = out_res_q.abort_cause;
  assign data_byte_o     = out_res_q.data_byte;
  assign payload_index_o = out_res_q.payload_index;
  assign frame_command_o = out_res_q.frame_command;
  assign frame_length_o  = out_res_q.frame_length;

endmodule

`default_nettype wire
